### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the battery gauge RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge while reset is released.
`define WBG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define WBG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WBG_ASSERT(lbl, clk, rst_n, prop, msg)
`define WBG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/wbg_pkg.sv
// ----------------------------------------------------------------------------
// wbg_pkg
// Types, field widths and register indexes of the windowed battery gauge.
// ----------------------------------------------------------------------------
package wbg_pkg;

    // Default parameter values.
    localparam int COUNT_BITS_DEF = 16;
    localparam int ADC_BITS_DEF   = 12;

    // Fixed field widths.
    localparam int RAW_W   = 12;
    localparam int PCT_W   = 15;
    localparam int MV_W    = 16;
    localparam int TICK_W  = 32;
    localparam int REF_W   = 13;
    localparam int SCALE_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fraction bits of the divider scale.
    localparam int Q8_SHIFT = 8;

    // One hundred percent in Q8.
    localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_EMPTY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_FULL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_CEILING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL  = 3'd6;

    // Register reset values.
    localparam logic [RAW_W-1:0]      RAW_EMPTY_RST = 12'd0;
    localparam logic [RAW_W-1:0]      RAW_FULL_RST  = 12'd4095;
    localparam logic [REF_W-1:0]      REF_MV_RST    = 13'd3300;
    localparam logic [SCALE_W-1:0]    DIV_SCALE_RST = 12'd512;
    localparam logic [MV_W-1:0]       V_CEILING_RST = 16'd16800;
    localparam logic [TICK_W-1:0]     WINDOW_RST    = 32'd1000;
    localparam logic [PCT_W-1:0]      CRITICAL_RST  = 15'd2560;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_GO,
        S_AVG_RUN,
        S_MUL_A,
        S_MUL_B,
        S_VOLT_GO,
        S_VOLT_RUN,
        S_PCT_GO,
        S_PCT_RUN,
        S_STORE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### sv/wbg_div.sv
// ----------------------------------------------------------------------------
// wbg_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module wbg_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DVS_W-1:0]    divisor,
    output wbg_pkg::div_status_t status,
    output logic [DVD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    // The dividend shifts out of the top of quo_reg while quotient bits
    // shift in at the bottom.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        if (fits)
        begin
            rem_next = DVS_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[DVS_W-1:0];
        end
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

### sv/windowed_battery_gauge.sv
// ----------------------------------------------------------------------------
// windowed_battery_gauge
// Windowed ADC average with charge percent and battery voltage conversion.
// ----------------------------------------------------------------------------
// An item that does not close a window goes to S_EMIT and then to the output
// register; in_stall stays high until S_IDLE, so the next word waits for it.
// An item that closes a window runs the average and percent divisions on the
// shared divider and folds the voltage by 2^ADC_BITS - 1; the percent division
// is skipped when the percent is zero, and out_stall holds the result word.
// Reset clears the sequencer, accumulator and stored results and returns the
// registers to their default values; products and output data are not reset.
`include "assert_macros.svh"

module windowed_battery_gauge #(
    parameter int COUNT_BITS = wbg_pkg::COUNT_BITS_DEF,
    parameter int ADC_BITS   = wbg_pkg::ADC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              sample_ok,
    input  logic [wbg_pkg::RAW_W-1:0]         sample_raw,
    input  logic [wbg_pkg::TICK_W-1:0]        tick_now,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              window_closed,
    output logic [wbg_pkg::RAW_W-1:0]         avg_raw,
    output logic [wbg_pkg::PCT_W-1:0]         percent_q8,
    output logic [wbg_pkg::MV_W-1:0]          voltage_mv,
    output logic                              level_valid,
    output logic                              critical,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wbg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int RAW_W    = wbg_pkg::RAW_W;
    localparam int PCT_W    = wbg_pkg::PCT_W;
    localparam int MV_W     = wbg_pkg::MV_W;
    localparam int SAMPLE_W = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam int SUM_W    = SAMPLE_W + COUNT_BITS;
    localparam int PROD1_W  = SAMPLE_W + wbg_pkg::REF_W;
    localparam int PROD2_W  = PROD1_W + wbg_pkg::SCALE_W;
    localparam int VDVD_W   = PROD2_W - wbg_pkg::Q8_SHIFT;
    localparam int PDVD_W   = RAW_W + PCT_W;
    localparam int DVD_W    = (SUM_W > PDVD_W) ? SUM_W : PDVD_W;
    localparam int DVS_W    = (COUNT_BITS > RAW_W) ? COUNT_BITS : RAW_W;
    localparam logic [VDVD_W-1:0] ADC_FULL = VDVD_W'((64'd1 << ADC_BITS) - 64'd1);

    // Configuration registers.
    logic [RAW_W-1:0]               raw_empty_reg;
    logic [RAW_W-1:0]               raw_full_reg;
    logic [wbg_pkg::REF_W-1:0]      ref_mv_reg;
    logic [wbg_pkg::SCALE_W-1:0]    div_scale_reg;
    logic [MV_W-1:0]                v_ceiling_reg;
    logic [wbg_pkg::TICK_W-1:0]     window_reg;
    logic [PCT_W-1:0]               critical_reg;

    wbg_pkg::state_t state_reg;
    wbg_pkg::state_t state_next;

    logic [SUM_W-1:0]               sum_reg;
    logic [COUNT_BITS-1:0]          count_reg;
    logic [wbg_pkg::TICK_W-1:0]     start_reg;
    logic [SAMPLE_W-1:0]            avg_reg;
    logic [PCT_W-1:0]               stored_pct_reg;
    logic [MV_W-1:0]                stored_volt_reg;
    logic                           stored_valid_reg;
    logic                           closed_reg;
    logic [PROD1_W-1:0]             prod1_reg;
    logic [PROD2_W-1:0]             prod2_reg;
    logic [PDVD_W-1:0]              pct_prod_reg;
    logic [VDVD_W-1:0]              volt_x_reg;
    logic [VDVD_W-1:0]              volt_q_reg;

    logic                           out_valid_reg;
    logic                           window_closed_reg;
    logic [RAW_W-1:0]               avg_raw_reg;
    logic [PCT_W-1:0]               percent_reg;
    logic [MV_W-1:0]                voltage_reg;
    logic                           level_valid_reg;
    logic                           crit_out_reg;

    logic                           in_fire;
    logic                           out_load;
    logic                           div_start;
    logic                           count_inc;
    logic                           expired;
    logic                           has_samples;
    logic [wbg_pkg::TICK_W-1:0]     win_len;
    logic [wbg_pkg::TICK_W-1:0]     elapsed;
    logic [RAW_W-1:0]               avg_ext;
    logic [RAW_W-1:0]               span;
    logic                           pct_zero;
    logic [VDVD_W-1:0]              volt_hi;
    logic [VDVD_W-1:0]              volt_lo;
    logic [VDVD_W-1:0]              volt_quo;
    logic                           volt_fold_done;
    logic [DVD_W-1:0]               div_dvd;
    logic [DVS_W-1:0]               div_dvs;
    logic [DVD_W-1:0]               div_quo;
    wbg_pkg::div_status_t           div_stat;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_empty_reg <= wbg_pkg::RAW_EMPTY_RST;
            raw_full_reg  <= wbg_pkg::RAW_FULL_RST;
            ref_mv_reg    <= wbg_pkg::REF_MV_RST;
            div_scale_reg <= wbg_pkg::DIV_SCALE_RST;
            v_ceiling_reg <= wbg_pkg::V_CEILING_RST;
            window_reg    <= wbg_pkg::WINDOW_RST;
            critical_reg  <= wbg_pkg::CRITICAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wbg_pkg::CFG_RAW_EMPTY: raw_empty_reg <= cfg_wdata[RAW_W-1:0];
                wbg_pkg::CFG_RAW_FULL:  raw_full_reg  <= cfg_wdata[RAW_W-1:0];
                wbg_pkg::CFG_REF_MV:    ref_mv_reg    <= cfg_wdata[wbg_pkg::REF_W-1:0];
                wbg_pkg::CFG_DIV_SCALE: div_scale_reg <= cfg_wdata[wbg_pkg::SCALE_W-1:0];
                wbg_pkg::CFG_V_CEILING: v_ceiling_reg <= cfg_wdata[MV_W-1:0];
                wbg_pkg::CFG_WINDOW:    window_reg    <= cfg_wdata[wbg_pkg::TICK_W-1:0];
                wbg_pkg::CFG_CRITICAL:  critical_reg  <= cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accumulate and window check
    // ------------------------------------------------------------------
    assign in_fire     = in_valid && !in_stall;
    assign count_inc   = sample_ok && !(&count_reg);
    assign has_samples = (count_reg != '0) || count_inc;
    assign win_len     = (window_reg == '0) ? wbg_pkg::TICK_W'(1) : window_reg;
    assign elapsed     = tick_now - start_reg;
    assign expired     = (elapsed >= win_len);

    assign avg_ext  = RAW_W'(avg_reg);
    assign span     = raw_full_reg - raw_empty_reg;
    assign pct_zero = (raw_full_reg <= raw_empty_reg) || (avg_ext <= raw_empty_reg);

    // Division by 2^ADC_BITS - 1: each step moves the part above ADC_BITS into
    // the quotient and adds it back to the low part, since 2^n equals one more
    // than the divisor. A remainder equal to the divisor adds one more.
    assign volt_hi        = volt_x_reg >> ADC_BITS;
    assign volt_lo        = volt_x_reg & ADC_FULL;
    assign volt_fold_done = (volt_hi == '0);
    assign volt_quo       = volt_q_reg + VDVD_W'(volt_x_reg == ADC_FULL);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wbg_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (expired && has_samples) ? wbg_pkg::S_AVG_GO
                                                          : wbg_pkg::S_EMIT;
                end
            end
            wbg_pkg::S_AVG_GO:   state_next = wbg_pkg::S_AVG_RUN;
            wbg_pkg::S_AVG_RUN:
            begin
                if (div_stat.done)
                begin
                    state_next = wbg_pkg::S_MUL_A;
                end
            end
            wbg_pkg::S_MUL_A:    state_next = wbg_pkg::S_MUL_B;
            wbg_pkg::S_MUL_B:    state_next = wbg_pkg::S_VOLT_GO;
            wbg_pkg::S_VOLT_GO:  state_next = wbg_pkg::S_VOLT_RUN;
            wbg_pkg::S_VOLT_RUN:
            begin
                if (volt_fold_done)
                begin
                    state_next = wbg_pkg::S_PCT_GO;
                end
            end
            wbg_pkg::S_PCT_GO:
            begin
                state_next = pct_zero ? wbg_pkg::S_STORE : wbg_pkg::S_PCT_RUN;
            end
            wbg_pkg::S_PCT_RUN:
            begin
                if (div_stat.done)
                begin
                    state_next = wbg_pkg::S_STORE;
                end
            end
            wbg_pkg::S_STORE:    state_next = wbg_pkg::S_EMIT;
            wbg_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = wbg_pkg::S_IDLE;
                end
            end
            default:             state_next = wbg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != wbg_pkg::S_IDLE);
        out_load  = (state_reg == wbg_pkg::S_EMIT) && (!out_valid_reg || !out_stall);
        div_start = (state_reg == wbg_pkg::S_AVG_GO) ||
                    ((state_reg == wbg_pkg::S_PCT_GO) && !pct_zero);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wbg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            wbg_pkg::S_AVG_GO:
            begin
                div_dvd = DVD_W'(sum_reg);
                div_dvs = DVS_W'(count_reg);
            end
            default:
            begin
                div_dvd = DVD_W'(pct_prod_reg);
                div_dvs = DVS_W'(span);
            end
        endcase
    end

    wbg_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .status   (div_stat),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Gauge state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            count_reg        <= '0;
            start_reg        <= '0;
            avg_reg          <= '0;
            stored_pct_reg   <= '0;
            stored_volt_reg  <= '0;
            stored_valid_reg <= 1'b0;
            closed_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                wbg_pkg::S_IDLE:
                begin
                    if (in_fire)
                    begin
                        closed_reg <= 1'b0;
                        if (count_inc)
                        begin
                            sum_reg   <= sum_reg + SUM_W'(sample_raw[SAMPLE_W-1:0]);
                            count_reg <= count_reg + COUNT_BITS'(1);
                        end
                        if (expired)
                        begin
                            start_reg <= tick_now;
                        end
                    end
                end
                wbg_pkg::S_AVG_RUN:
                begin
                    if (div_stat.done)
                    begin
                        avg_reg <= div_quo[SAMPLE_W-1:0];
                    end
                end
                wbg_pkg::S_VOLT_RUN:
                begin
                    if (volt_fold_done)
                    begin
                        if (volt_quo > VDVD_W'(v_ceiling_reg))
                        begin
                            stored_volt_reg <= v_ceiling_reg;
                        end
                        else
                        begin
                            stored_volt_reg <= volt_quo[MV_W-1:0];
                        end
                    end
                end
                wbg_pkg::S_STORE:
                begin
                    if (pct_zero)
                    begin
                        stored_pct_reg <= '0;
                    end
                    else if (div_quo > DVD_W'(wbg_pkg::PCT_FULL))
                    begin
                        stored_pct_reg <= wbg_pkg::PCT_FULL;
                    end
                    else
                    begin
                        stored_pct_reg <= div_quo[PCT_W-1:0];
                    end
                    stored_valid_reg <= 1'b1;
                    closed_reg       <= 1'b1;
                    sum_reg          <= '0;
                    count_reg        <= '0;
                end
                default: ;
            endcase
        end
    end

    // Products feeding the voltage and percent divisions.
    always_ff @(posedge clk)
    begin
        if (state_reg == wbg_pkg::S_MUL_A)
        begin
            prod1_reg    <= PROD1_W'(avg_reg) * PROD1_W'(ref_mv_reg);
            pct_prod_reg <= PDVD_W'(avg_ext - raw_empty_reg) * PDVD_W'(wbg_pkg::PCT_FULL);
        end
        if (state_reg == wbg_pkg::S_MUL_B)
        begin
            prod2_reg <= PROD2_W'(prod1_reg) * PROD2_W'(div_scale_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == wbg_pkg::S_VOLT_GO)
        begin
            volt_x_reg <= prod2_reg[PROD2_W-1:wbg_pkg::Q8_SHIFT];
            volt_q_reg <= '0;
        end
        else if ((state_reg == wbg_pkg::S_VOLT_RUN) && !volt_fold_done)
        begin
            volt_q_reg <= volt_q_reg + volt_hi;
            volt_x_reg <= volt_hi + volt_lo;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            window_closed_reg <= closed_reg;
            avg_raw_reg       <= avg_ext;
            percent_reg       <= stored_pct_reg;
            voltage_reg       <= stored_volt_reg;
            level_valid_reg   <= stored_valid_reg;
            crit_out_reg      <= stored_valid_reg && (stored_pct_reg <= critical_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_closed = window_closed_reg;
    assign avg_raw       = avg_raw_reg;
    assign percent_q8    = percent_reg;
    assign voltage_mv    = voltage_reg;
    assign level_valid   = level_valid_reg;
    assign critical      = crit_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WBG_ASSERT(a_pct_range, clk, rst_n, stored_pct_reg <= wbg_pkg::PCT_FULL, "percent above full scale")
    `WBG_ASSERT(a_div_free, clk, rst_n, div_start |-> !div_stat.busy, "divider started while busy")
    `WBG_ASSERT(a_idle_div, clk, rst_n, (state_reg == wbg_pkg::S_IDLE) |-> !div_stat.busy, "divider busy in idle")
    `WBG_ASSERT(a_store_clr, clk, rst_n, (state_reg == wbg_pkg::S_STORE) |=> (count_reg == '0), "count not cleared")
    `WBG_ASSERT(a_closed_lvl, clk, rst_n, (out_valid_reg && window_closed_reg) |-> level_valid_reg, "closed word without level")

endmodule

### tb/sv/windowed_battery_gauge_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_battery_gauge_tb
// Self-checking bench for the windowed battery gauge. Sample words are sent
// from a queue. Each accepted word is run through a behavioral gauge model
// kept in this file. Every result word is compared field by field with the
// model's report. Register settings change between phases, and both sides of
// the stream idle and stall at random.
// ----------------------------------------------------------------------------
module windowed_battery_gauge_tb;

    localparam int RAW_W      = wbg_pkg::RAW_W;
    localparam int PCT_W      = wbg_pkg::PCT_W;
    localparam int MV_W       = wbg_pkg::MV_W;
    localparam int TICK_W     = wbg_pkg::TICK_W;
    localparam int REF_W      = wbg_pkg::REF_W;
    localparam int SCALE_W    = wbg_pkg::SCALE_W;
    localparam int CFG_IDX_W  = wbg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wbg_pkg::CFG_DATA_W;
    localparam int Q8_SHIFT   = wbg_pkg::Q8_SHIFT;
    localparam logic [PCT_W-1:0] PCT_FULL = wbg_pkg::PCT_FULL;

    localparam int SUM_W    = 28;
    localparam int ADC_FULL = (1 << wbg_pkg::ADC_BITS_DEF) - 1;
    localparam logic [wbg_pkg::COUNT_BITS_DEF-1:0] COUNT_FULL = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam int RANDOM_TARGET = 1250;

    typedef struct packed {
        logic              ok;
        logic [RAW_W-1:0]  raw;
        logic [TICK_W-1:0] tick;
    } sample_t;

    typedef struct packed {
        logic              closed;
        logic [RAW_W-1:0]  avg;
        logic [PCT_W-1:0]  pct;
        logic [MV_W-1:0]   mv;
        logic              valid;
        logic              crit;
    } report_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  sample_ok   = 1'b0;
    logic [RAW_W-1:0]      sample_raw  = '0;
    logic [TICK_W-1:0]     tick_now    = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  window_closed;
    logic [RAW_W-1:0]      avg_raw;
    logic [PCT_W-1:0]      percent_q8;
    logic [MV_W-1:0]       voltage_mv;
    logic                  level_valid;
    logic                  critical;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    // Gauge model: register copies and accumulator state.
    logic [RAW_W-1:0]          reg_empty   = wbg_pkg::RAW_EMPTY_RST;
    logic [RAW_W-1:0]          reg_full    = wbg_pkg::RAW_FULL_RST;
    logic [REF_W-1:0]          reg_ref     = wbg_pkg::REF_MV_RST;
    logic [SCALE_W-1:0]        reg_scale   = wbg_pkg::DIV_SCALE_RST;
    logic [MV_W-1:0]           reg_ceiling = wbg_pkg::V_CEILING_RST;
    logic [TICK_W-1:0]         reg_window  = wbg_pkg::WINDOW_RST;
    logic [PCT_W-1:0]          reg_crit    = wbg_pkg::CRITICAL_RST;
    logic [SUM_W-1:0]          acc_sum     = '0;
    logic [wbg_pkg::COUNT_BITS_DEF-1:0] acc_count = '0;
    logic [TICK_W-1:0]         win_start   = '0;
    logic [RAW_W-1:0]          held_avg    = '0;
    logic [PCT_W-1:0]          held_pct    = '0;
    logic [MV_W-1:0]           held_mv     = '0;
    logic                      held_valid  = 1'b0;

    // The generator follows the window start so it can aim at the boundaries.
    logic [TICK_W-1:0] gen_start = '0;
    logic [TICK_W-1:0] last_tick = '0;

    sample_t pending_samples[$];
    report_t expected_reports[$];

    int samples_queued = 0;
    int samples_taken  = 0;
    int reports_seen   = 0;
    int windows_seen   = 0;
    int cfg_writes     = 0;
    int random_items   = 0;
    int errors         = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;

    windowed_battery_gauge i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_ok     (sample_ok),
        .sample_raw    (sample_raw),
        .tick_now      (tick_now),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_closed (window_closed),
        .avg_raw       (avg_raw),
        .percent_q8    (percent_q8),
        .voltage_mv    (voltage_mv),
        .level_valid   (level_valid),
        .critical      (critical),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic logic [TICK_W-1:0] window_len();
        return (reg_window == '0) ? 32'd1 : reg_window;
    endfunction

    function automatic logic [PCT_W-1:0] percent_of(logic [RAW_W-1:0] a);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        if (reg_full <= reg_empty || a <= reg_empty)
            return '0;
        num = a;
        num = num - reg_empty;
        den = reg_full;
        den = den - reg_empty;
        q = num * PCT_FULL / den;
        if (q > PCT_FULL)
            q = PCT_FULL;
        return PCT_W'(q);
    endfunction

    function automatic logic [MV_W-1:0] voltage_of(logic [RAW_W-1:0] a);
        longint unsigned v;
        v = a;
        v = v * reg_ref * reg_scale;
        v = v / (ADC_FULL << Q8_SHIFT);
        if (v > reg_ceiling)
            v = reg_ceiling;
        return MV_W'(v);
    endfunction

    // Advances the gauge model by one sample period and returns its report.
    function automatic report_t gauge_step(sample_t s);
        report_t r;
        logic [RAW_W-1:0] a;
        r = '0;
        if (s.ok && acc_count != COUNT_FULL)
        begin
            acc_sum   = acc_sum + SUM_W'(s.raw);
            acc_count = acc_count + 1'b1;
        end
        if (TICK_W'(s.tick - win_start) >= window_len())
        begin
            win_start = s.tick;
            if (acc_count != '0)
            begin
                a          = RAW_W'(acc_sum / acc_count);
                held_avg   = a;
                held_pct   = percent_of(a);
                held_mv    = voltage_of(a);
                held_valid = 1'b1;
                acc_sum    = '0;
                acc_count  = '0;
                r.closed   = 1'b1;
            end
        end
        r.avg   = held_avg;
        r.pct   = held_pct;
        r.mv    = held_mv;
        r.valid = held_valid;
        r.crit  = held_valid && (held_pct <= reg_crit);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [31:0] with_junk(logic [31:0] val, int width);
        logic [31:0] junk;
        junk = $urandom();
        if (width < 32 && $urandom_range(3) == 0)
            return val | (junk << width);
        return val;
    endfunction

    // Sender: presents queued sample words and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        sample_t s;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            sample_ok  <= 1'b0;
            sample_raw <= '0;
            tick_now   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s.ok   = sample_ok;
                s.raw  = sample_raw;
                s.tick = tick_now;
                expected_reports.push_back(gauge_step(s));
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    s = pending_samples.pop_front();
                    in_valid   <= 1'b1;
                    sample_ok  <= s.ok;
                    sample_raw <= s.raw;
                    tick_now   <= s.tick;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: result word arrived with no sample waiting for it", $time);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (want.closed)
                        windows_seen++;
                    check_field("window_closed", want.closed, window_closed);
                    check_field("avg_raw", want.avg, avg_raw);
                    check_field("percent_q8", want.pct, percent_q8);
                    check_field("voltage_mv", want.mv, voltage_mv);
                    check_field("level_valid", want.valid, level_valid);
                    check_field("critical", want.crit, critical);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            wbg_pkg::CFG_RAW_EMPTY: reg_empty   = data[RAW_W-1:0];
            wbg_pkg::CFG_RAW_FULL:  reg_full    = data[RAW_W-1:0];
            wbg_pkg::CFG_REF_MV:    reg_ref     = data[REF_W-1:0];
            wbg_pkg::CFG_DIV_SCALE: reg_scale   = data[SCALE_W-1:0];
            wbg_pkg::CFG_V_CEILING: reg_ceiling = data[MV_W-1:0];
            wbg_pkg::CFG_WINDOW:    reg_window  = data;
            wbg_pkg::CFG_CRITICAL:  reg_crit    = data[PCT_W-1:0];
            default:                ;
        endcase
    endtask

    task automatic queue_sample(logic ok, logic [RAW_W-1:0] raw, logic [TICK_W-1:0] tick);
        sample_t s;
        s.ok   = ok;
        s.raw  = raw;
        s.tick = tick;
        pending_samples.push_back(s);
        samples_queued++;
        if (TICK_W'(tick - gen_start) >= window_len())
            gen_start = tick;
        last_tick = tick;
    endtask

    task automatic queue_random_sample();
        logic [TICK_W-1:0] len;
        logic [TICK_W-1:0] hi;
        logic [TICK_W-1:0] tick;
        logic [RAW_W-1:0]  raw;
        int r;
        len = window_len();
        hi  = (len > 32'hC000_0000) ? 32'hFFFF_FFFF : len + (len >> 2);
        r   = $urandom_range(99);
        if (r < 10)
            tick = gen_start + len;
        else if (r < 18)
            tick = gen_start + len - 1;
        else if (r < 26)
            tick = $urandom();
        else if (r < 30)
            tick = last_tick;
        else
            tick = gen_start + $urandom_range(hi);
        case ($urandom_range(9))
            0:       raw = '0;
            1:       raw = '1;
            2:       raw = reg_empty;
            3:       raw = reg_full;
            default: raw = RAW_W'($urandom());
        endcase
        queue_sample($urandom_range(99) < 85, raw, tick);
    endtask

    // Returns once every queued word is taken and every result has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (samples_taken != samples_queued || expected_reports.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1:       begin idle_pct = 48; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 48; end
            3:       begin idle_pct = 13; stall_pct = 13; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic write_random_config();
        logic [RAW_W-1:0]   e;
        logic [RAW_W-1:0]   f;
        logic [TICK_W-1:0]  w;
        logic [CFG_DATA_W-1:0] v;
        int r;
        r = $urandom_range(99);
        if (r < 25)
            e = '0;
        else if (r < 40)
            e = '1;
        else
            e = RAW_W'($urandom());
        r = $urandom_range(99);
        if (r < 60 && e != '1)
            f = RAW_W'($urandom_range(ADC_FULL, e + 1));
        else if (r < 75)
            f = e;
        else
            f = RAW_W'($urandom());
        cfg_write(wbg_pkg::CFG_RAW_EMPTY, with_junk(e, RAW_W));
        cfg_write(wbg_pkg::CFG_RAW_FULL, with_junk(f, RAW_W));

        r = $urandom_range(99);
        if (r < 20)
            v = 0;
        else if (r < 40)
            v = 5000;
        else if (r < 50)
            v = (1 << REF_W) - 1;
        else
            v = $urandom_range(5000);
        cfg_write(wbg_pkg::CFG_REF_MV, with_junk(v, REF_W));

        r = $urandom_range(99);
        v = (r < 20) ? 0 : (r < 40) ? (1 << SCALE_W) - 1 : $urandom_range((1 << SCALE_W) - 1);
        cfg_write(wbg_pkg::CFG_DIV_SCALE, with_junk(v, SCALE_W));

        r = $urandom_range(99);
        v = (r < 20) ? 0 : (r < 40) ? (1 << MV_W) - 1 : $urandom_range((1 << MV_W) - 1);
        cfg_write(wbg_pkg::CFG_V_CEILING, with_junk(v, MV_W));

        case ($urandom_range(9))
            0:       w = '0;
            1:       w = 1;
            2:       w = '1;
            3:       w = $urandom();
            4, 5:    w = $urandom_range(64, 2);
            default: w = $urandom_range(5000, 65);
        endcase
        cfg_write(wbg_pkg::CFG_WINDOW, w);

        r = $urandom_range(99);
        if (r < 20)
            v = 0;
        else if (r < 40)
            v = PCT_FULL;
        else if (r < 50)
            v = (1 << PCT_W) - 1;
        else
            v = $urandom_range(PCT_FULL);
        cfg_write(wbg_pkg::CFG_CRITICAL, with_junk(v, PCT_W));

        if ($urandom_range(1) == 1)
            cfg_write(CFG_UNMAPPED, $urandom());
    endtask

    // Sends a burst in two halves and lets the gauge empty out in between.
    task automatic run_random_phase(int n, int mode);
        set_idling(mode);
        for (int i = 0; i < n; i++)
        begin
            queue_random_sample();
            if (i == n / 2)
                wait_drained();
        end
        random_items += n;
        wait_drained();
    endtask

    initial
    begin
        int phases;
        phases = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a plain window, a masked-out raw value, an empty
        // window, and a window that spans the tick wraparound.
        set_idling(0);
        queue_sample(1'b1, 12'd0, 32'd0);
        queue_sample(1'b1, 12'd4095, 32'd500);
        queue_sample(1'b0, 12'd4095, 32'd999);
        queue_sample(1'b1, 12'd2048, 32'd1000);
        queue_sample(1'b0, 12'd0, 32'd1500);
        queue_sample(1'b0, 12'd0, 32'd2000);
        queue_sample(1'b1, 12'd4095, 32'd2999);
        queue_sample(1'b1, 12'd0, 32'd3000);
        queue_sample(1'b1, 12'd1, 32'hFFFF_FFF0);
        queue_sample(1'b1, 12'd100, 32'hFFFF_FFF8);
        queue_sample(1'b1, 12'd200, 32'd984);
        wait_drained();

        // Zero window length, saturated percent and voltage, top threshold.
        cfg_write(wbg_pkg::CFG_WINDOW, 32'd0);
        cfg_write(wbg_pkg::CFG_RAW_EMPTY, 32'd100);
        cfg_write(wbg_pkg::CFG_RAW_FULL, 32'd3000);
        cfg_write(wbg_pkg::CFG_CRITICAL, 32'(PCT_FULL));
        cfg_write(wbg_pkg::CFG_REF_MV, 32'hFFFF_F388);
        cfg_write(wbg_pkg::CFG_DIV_SCALE, 32'd4095);
        cfg_write(wbg_pkg::CFG_V_CEILING, 32'hFFFF_FFFF);
        cfg_write(CFG_UNMAPPED, 32'hA5A5_5A5A);
        queue_sample(1'b1, 12'd50, 32'd5000);
        queue_sample(1'b1, 12'd3500, 32'd5000);
        queue_sample(1'b1, 12'd4095, 32'd5001);
        queue_sample(1'b0, 12'd4095, 32'd5002);
        queue_sample(1'b1, 12'd3000, 32'd5003);
        wait_drained();

        // Inverted calibration and every scale at zero.
        cfg_write(wbg_pkg::CFG_RAW_EMPTY, 32'd4095);
        cfg_write(wbg_pkg::CFG_RAW_FULL, 32'd0);
        cfg_write(wbg_pkg::CFG_REF_MV, 32'd0);
        cfg_write(wbg_pkg::CFG_DIV_SCALE, 32'd0);
        cfg_write(wbg_pkg::CFG_V_CEILING, 32'd0);
        cfg_write(wbg_pkg::CFG_CRITICAL, 32'd0);
        cfg_write(wbg_pkg::CFG_WINDOW, 32'd1);
        run_random_phase(60, 1);
        phases++;

        while (random_items < RANDOM_TARGET)
        begin
            write_random_config();
            run_random_phase($urandom_range(200, 80), phases % 4);
            phases++;
        end

        set_idling(0);
        repeat (120) @(posedge clk);
        $display("Covered %0d samples and %0d result words; %0d windows closed with samples.",
                 samples_taken, reports_seen, windows_seen);
        $display("Register writes: %0d across %0d randomized phases; %0d mismatches.",
                 cfg_writes, phases, errors);
        if (errors == 0)
            $display("windowed_battery_gauge verification clean");
        else
            $display("windowed_battery_gauge verification failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Timeout with %0d results still outstanding.", expected_reports.size());
        $display("windowed_battery_gauge verification failed");
        $finish;
    end

endmodule
